/* rtl/svpwm_pkg.sv */
// Shared types and constants of the two-level SVPWM duty core.
// No dependencies; imported by the top level.
package svpwm_pkg;

    localparam int SQ3_Q16     = 113512;   // sqrt(3) in Q16
    localparam int PERIOD_Q16  = 65536;    // PWM period in Q16
    localparam int CMP_W       = 16;
    localparam int TRAW_W      = 17;       // a dwell time of at most one period
    localparam int HALVE_LIMIT = 44;       // dwell sums are halved down below 2^44

    localparam logic [CMP_W-1:0] CMP_QUARTER = 16'd16384;
    localparam logic [CMP_W-1:0] CMP_HALF    = 16'd32768;

    typedef logic [2:0] t_sector;

    localparam t_sector SECTOR_1 = 3'd1;
    localparam t_sector SECTOR_2 = 3'd2;
    localparam t_sector SECTOR_3 = 3'd3;
    localparam t_sector SECTOR_4 = 3'd4;
    localparam t_sector SECTOR_5 = 3'd5;
    localparam t_sector SECTOR_6 = 3'd6;

    // indexed by the sign-test code {-ka-bs>0, ka-bs>0, beta>0}
    // zero vector and the impossible code map to sector 1
    localparam t_sector SECTOR_OF_CODE [8] = '{
        SECTOR_1, SECTOR_2, SECTOR_6, SECTOR_1,
        SECTOR_4, SECTOR_3, SECTOR_5, SECTOR_1
    };

    typedef struct packed {
        t_sector sector;
        logic    bus_zero;
    } t_item_info;

    typedef struct packed {
        t_item_info          item;
        logic                ovf;
        logic                q16_a;
        logic                q16_b;
        logic [TRAW_W-1:0]   t1_raw;
        logic [TRAW_W-1:0]   t2_raw;
    } t_scale_info;

    typedef struct packed {
        logic [CMP_W-1:0] cmp_a;
        logic [CMP_W-1:0] cmp_b;
        logic [CMP_W-1:0] cmp_c;
        t_sector          sector;
        logic             ovf;
    } t_result;

endpackage

/* rtl/svpwm_div.sv */
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Standalone; carries an opaque sideband word alongside the lanes.
module svpwm_div #(
    parameter int NB = 16,  // quotient bits (and stages)
    parameter int DW = 17,  // divisor width
    parameter int SW = 4    // sideband width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_side,
    input  logic [DW-1:0] i_divisor,
    input  logic [NB-1:0] i_num_a,
    input  logic [NB-1:0] i_num_b,
    input  logic [DW-1:0] i_rem_a,   // starting remainder, below the divisor
    input  logic [DW-1:0] i_rem_b,
    output logic          o_valid,
    output logic [SW-1:0] o_side,
    output logic [NB-1:0] o_quo_a,
    output logic [NB-1:0] o_quo_b
);

    // numerator bits shift out at the top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [NB-1:0] nq;
    } t_lane;

    function automatic t_lane div_step(input t_lane cur, input logic [DW-1:0] d);
        logic [DW:0] trial;
        t_lane       nxt;
        trial = {cur.rem, cur.nq[NB-1]};
        if (trial >= {1'b0, d}) begin
            nxt.rem = DW'(trial - {1'b0, d});
            nxt.nq  = {cur.nq[NB-2:0], 1'b1};
        end else begin
            nxt.rem = trial[DW-1:0];
            nxt.nq  = {cur.nq[NB-2:0], 1'b0};
        end
        return nxt;
    endfunction

    logic          r_valid [NB];
    logic [SW-1:0] r_side  [NB];
    logic [DW-1:0] r_div   [NB];
    t_lane         r_a     [NB];
    t_lane         r_b     [NB];

    logic          w_valid [NB];
    logic [SW-1:0] w_side  [NB];
    logic [DW-1:0] w_div   [NB];
    t_lane         w_a     [NB];
    t_lane         w_b     [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_valid[k] = i_valid;
            assign w_side[k]  = i_side;
            assign w_div[k]   = i_divisor;
            assign w_a[k]     = {i_rem_a, i_num_a};
            assign w_b[k]     = {i_rem_b, i_num_b};
        end else begin : g_next
            assign w_valid[k] = r_valid[k-1];
            assign w_side[k]  = r_side[k-1];
            assign w_div[k]   = r_div[k-1];
            assign w_a[k]     = r_a[k-1];
            assign w_b[k]     = r_b[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side[k];
                r_div[k]  <= w_div[k];
                r_a[k]    <= div_step(w_a[k], w_div[k]);
                r_b[k]    <= div_step(w_b[k], w_div[k]);
            end
        end
    end

    assign o_valid = r_valid[NB-1];
    assign o_side  = r_side[NB-1];
    assign o_quo_a = r_a[NB-1].nq;
    assign o_quo_b = r_b[NB-1].nq;

endmodule

/* rtl/svpwm_two_level_duty_core.sv */
// Two-level space vector PWM duty core: sector, dwell times, overmodulation scaling, compares.
// Depends on svpwm_pkg and svpwm_div.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_v_alpha, i_v_beta, i_bus_voltage
//   result   out        o_valid / i_ready    o_cmp_phase_a/b/c, o_sector_number,
//                                            o_overmodulated
//
// One beat in per cycle while o_ready is high, one result out per beat. The pipeline holds
// H = max(0, SAMPLE_WIDTH - 25) halving stages between the (SAMPLE_WIDTH+18)-stage dwell
// divider and the 16-stage scaling divider.
// Reset is synchronous, active low; it clears valid bits only.
// A stalled result moves into a skid register; o_ready drops only while that register is
// full, and the whole pipeline then holds.
module svpwm_two_level_duty_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_v_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] i_v_beta,
    input  logic [SAMPLE_WIDTH-1:0]      i_bus_voltage,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [svpwm_pkg::CMP_W-1:0]  o_cmp_phase_a,
    output logic [svpwm_pkg::CMP_W-1:0]  o_cmp_phase_b,
    output logic [svpwm_pkg::CMP_W-1:0]  o_cmp_phase_c,
    output svpwm_pkg::t_sector           o_sector_number,
    output logic                         o_overmodulated
);
    import svpwm_pkg::*;

    localparam int W    = SAMPLE_WIDTH;
    localparam int PW   = W + 20;              // signed working width
    localparam int NW   = W + 18;              // dwell numerator / quotient width
    localparam int DVW  = W + 1;               // divisor 2*bus
    localparam int TW   = NW;
    localparam int HS   = (TW > HALVE_LIMIT - 1) ? TW - (HALVE_LIMIT - 1) : 0;
    localparam int SUMW = (HS == 0) ? TW + 1 : HALVE_LIMIT;

    localparam logic signed [PW-1:0] SQ3_P  = PW'(SQ3_Q16);
    localparam logic signed [PW-1:0] ZERO_P = '0;

    logic w_en;
    logic r_skid_valid;
    assign w_en = !r_skid_valid;

    // ---- stage 1: constant multiplies
    logic                 r1_valid;
    logic signed [PW-1:0] r1_ka, r1_kb;
    logic signed [W-1:0]  r1_a, r1_b;
    logic [W-1:0]         r1_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ka  <= SQ3_P * PW'(i_v_alpha);
            r1_kb  <= SQ3_P * PW'(i_v_beta);
            r1_a   <= i_v_alpha;
            r1_b   <= i_v_beta;
            r1_bus <= i_bus_voltage;
        end
    end

    // ---- stage 2: sign tests, X/Y/Z numerators over a common divisor of 2*bus
    logic signed [PW-1:0] w_bs, w_a3;
    logic [2:0]           w_code;

    assign w_bs = PW'(r1_b) <<< 16;
    assign w_a3 = (PW'(r1_a) <<< 17) + (PW'(r1_a) <<< 16);

    always_comb begin
        w_code[0] = PW'(r1_b) > ZERO_P;
        w_code[1] = (r1_ka - w_bs) > ZERO_P;
        w_code[2] = (-r1_ka - w_bs) > ZERO_P;
    end

    logic                 r2_valid;
    t_item_info           r2_info;
    logic signed [PW-1:0] r2_nx, r2_ny, r2_nz;
    logic [DVW-1:0]       r2_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_info.sector   <= SECTOR_OF_CODE[w_code];
            r2_info.bus_zero <= (r1_bus == '0);
            r2_nx            <= r1_kb <<< 1;     // X = 2*kb / (2*bus)
            r2_ny            <= r1_kb + w_a3;
            r2_nz            <= r1_kb - w_a3;
            r2_div           <= {r1_bus, 1'b0};
        end
    end

    // ---- stage 3: pick t1/t2 numerators by sector, clamp negatives to zero
    logic signed [PW-1:0] w_m1, w_m2;

    always_comb begin
        case (r2_info.sector)
            SECTOR_1: begin w_m1 = -r2_nz; w_m2 = r2_nx;  end
            SECTOR_2: begin w_m1 = r2_nz;  w_m2 = r2_ny;  end
            SECTOR_3: begin w_m1 = r2_nx;  w_m2 = -r2_ny; end
            SECTOR_4: begin w_m1 = -r2_nx; w_m2 = r2_nz;  end
            SECTOR_5: begin w_m1 = -r2_ny; w_m2 = -r2_nz; end
            default:  begin w_m1 = r2_ny;  w_m2 = -r2_nx; end
        endcase
    end

    logic           r3_valid;
    t_item_info     r3_info;
    logic [NW-1:0]  r3_num1, r3_num2;
    logic [DVW-1:0] r3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_info <= r2_info;
            r3_num1 <= (w_m1 > ZERO_P) ? w_m1[NW-1:0] : '0;
            r3_num2 <= (w_m2 > ZERO_P) ? w_m2[NW-1:0] : '0;
            r3_div  <= r2_div;
        end
    end

    // ---- dwell divider
    logic       w_dv_valid;
    t_item_info w_dv_info;
    logic [TW-1:0] w_q1, w_q2;

    svpwm_div #(
        .NB (NW),
        .DW (DVW),
        .SW ($bits(t_item_info))
    ) u_dwell_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r3_valid),
        .i_side    (r3_info),
        .i_divisor (r3_div),
        .i_num_a   (r3_num1),
        .i_num_b   (r3_num2),
        .i_rem_a   ('0),
        .i_rem_b   ('0),
        .o_valid   (w_dv_valid),
        .o_side    (w_dv_info),
        .o_quo_a   (w_q1),
        .o_quo_b   (w_q2)
    );

    // ---- sum stage (index 0) and halving stages (1..HS)
    logic                r_h_valid [HS+1];
    t_item_info          r_h_info  [HS+1];
    logic                r_h_ovf   [HS+1];
    logic [TRAW_W-1:0]   r_h_raw1  [HS+1];
    logic [TRAW_W-1:0]   r_h_raw2  [HS+1];
    logic [TW-1:0]       r_h_t1    [HS+1];
    logic [TW-1:0]       r_h_t2    [HS+1];
    logic [TW:0]         r_h_sum   [HS+1];

    logic [TW:0] n_sum;
    assign n_sum = (TW+1)'(w_q1) + (TW+1)'(w_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid[0] <= 1'b0;
        end else if (w_en) begin
            r_h_valid[0] <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_info[0] <= w_dv_info;
            r_h_ovf[0]  <= n_sum > (TW+1)'(PERIOD_Q16);
            r_h_raw1[0] <= w_q1[TRAW_W-1:0];
            r_h_raw2[0] <= w_q2[TRAW_W-1:0];
            r_h_t1[0]   <= w_q1;
            r_h_t2[0]   <= w_q2;
            r_h_sum[0]  <= n_sum;
        end
    end

    for (genvar k = 1; k <= HS; k++) begin : g_halve
        logic          w_big;
        logic [TW-1:0] n_t1, n_t2;

        assign w_big = |r_h_sum[k-1][TW:HALVE_LIMIT];
        assign n_t1  = w_big ? (r_h_t1[k-1] >> 1) : r_h_t1[k-1];
        assign n_t2  = w_big ? (r_h_t2[k-1] >> 1) : r_h_t2[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_h_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_h_valid[k] <= r_h_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_h_info[k] <= r_h_info[k-1];
                r_h_ovf[k]  <= r_h_ovf[k-1];
                r_h_raw1[k] <= r_h_raw1[k-1];
                r_h_raw2[k] <= r_h_raw2[k-1];
                r_h_t1[k]   <= n_t1;
                r_h_t2[k]   <= n_t2;
                r_h_sum[k]  <= (TW+1)'(n_t1) + (TW+1)'(n_t2);
            end
        end
    end

    // ---- prep stage: top quotient bit (t == sum) and starting remainders
    logic [SUMW-1:0] w_l_t1, w_l_t2, w_l_sum;
    assign w_l_t1  = SUMW'(r_h_t1[HS]);
    assign w_l_t2  = SUMW'(r_h_t2[HS]);
    assign w_l_sum = SUMW'(r_h_sum[HS]);

    logic            r_p_valid;
    t_scale_info     r_p_side;
    logic [SUMW-1:0] r_p_rem1, r_p_rem2, r_p_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= r_h_valid[HS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_side.item   <= r_h_info[HS];
            r_p_side.ovf    <= r_h_ovf[HS];
            r_p_side.q16_a  <= (w_l_t1 == w_l_sum);
            r_p_side.q16_b  <= (w_l_t2 == w_l_sum);
            r_p_side.t1_raw <= r_h_raw1[HS];
            r_p_side.t2_raw <= r_h_raw2[HS];
            r_p_rem1        <= (w_l_t1 == w_l_sum) ? '0 : w_l_t1;
            r_p_rem2        <= (w_l_t2 == w_l_sum) ? '0 : w_l_t2;
            r_p_sum         <= w_l_sum;
        end
    end

    // ---- scaling divider: t * 65536 / sum, low 16 quotient bits
    logic             w_sc_valid;
    t_scale_info      w_sc_side;
    logic [CMP_W-1:0] w_s1, w_s2;

    svpwm_div #(
        .NB (CMP_W),
        .DW (SUMW),
        .SW ($bits(t_scale_info))
    ) u_scale_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_p_valid),
        .i_side    (r_p_side),
        .i_divisor (r_p_sum),
        .i_num_a   ('0),
        .i_num_b   ('0),
        .i_rem_a   (r_p_rem1),
        .i_rem_b   (r_p_rem2),
        .o_valid   (w_sc_valid),
        .o_side    (w_sc_side),
        .o_quo_a   (w_s1),
        .o_quo_b   (w_s2)
    );

    // ---- final stage: zero-vector time and half dwells
    logic [TRAW_W-1:0] w_t1f, w_t2f, w_rest;

    assign w_t1f  = w_sc_side.ovf ? {w_sc_side.q16_a, w_s1} : w_sc_side.t1_raw;
    assign w_t2f  = w_sc_side.ovf ? {w_sc_side.q16_b, w_s2} : w_sc_side.t2_raw;
    assign w_rest = TRAW_W'(PERIOD_Q16) - w_t1f - w_t2f;

    logic             r_f_valid;
    t_item_info       r_f_info;
    logic             r_f_ovf;
    logic [14:0]      r_f_ta;
    logic [CMP_W-1:0] r_f_h1, r_f_h2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_sc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_info <= w_sc_side.item;
            r_f_ovf  <= w_sc_side.ovf;
            r_f_ta   <= w_rest[TRAW_W-1:2];
            r_f_h1   <= w_t1f[TRAW_W-1:1];
            r_f_h2   <= w_t2f[TRAW_W-1:1];
        end
    end

    // ---- result: compare ordering by sector
    logic [CMP_W-1:0] w_ta, w_tb, w_tc;
    t_result          w_res;

    assign w_ta = CMP_W'(r_f_ta);
    assign w_tb = w_ta + r_f_h1;
    assign w_tc = w_tb + r_f_h2;

    always_comb begin
        w_res.sector = r_f_info.sector;
        w_res.ovf    = r_f_ovf;
        case (r_f_info.sector)
            SECTOR_1: begin w_res.cmp_a = w_ta; w_res.cmp_b = w_tb; w_res.cmp_c = w_tc; end
            SECTOR_2: begin w_res.cmp_a = w_tb; w_res.cmp_b = w_ta; w_res.cmp_c = w_tc; end
            SECTOR_3: begin w_res.cmp_a = w_tc; w_res.cmp_b = w_ta; w_res.cmp_c = w_tb; end
            SECTOR_4: begin w_res.cmp_a = w_tc; w_res.cmp_b = w_tb; w_res.cmp_c = w_ta; end
            SECTOR_5: begin w_res.cmp_a = w_tb; w_res.cmp_b = w_tc; w_res.cmp_c = w_ta; end
            default:  begin w_res.cmp_a = w_ta; w_res.cmp_b = w_tc; w_res.cmp_c = w_tb; end
        endcase
        if (r_f_info.bus_zero) begin
            w_res.cmp_a = CMP_QUARTER;
            w_res.cmp_b = CMP_QUARTER;
            w_res.cmp_c = CMP_QUARTER;
            w_res.ovf   = 1'b1;
        end
    end

    // ---- output register with skid
    logic    r_out_valid;
    t_result r_out, r_skid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_valid <= r_f_valid;
        end else if (r_f_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (w_out_free) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_ready         = w_en;
    assign o_valid         = r_out_valid;
    assign o_cmp_phase_a   = r_out.cmp_a;
    assign o_cmp_phase_b   = r_out.cmp_b;
    assign o_cmp_phase_c   = r_out.cmp_c;
    assign o_sector_number = r_out.sector;
    assign o_overmodulated = r_out.ovf;

`ifndef ASSERT_OFF
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sector_number >= SECTOR_1 && o_sector_number <= SECTOR_6))
        else $error("sector out of range");

    a_cmp_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cmp_phase_a <= CMP_HALF && o_cmp_phase_b <= CMP_HALF &&
                     o_cmp_phase_c <= CMP_HALF))
        else $error("compare above half period");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready && r_f_valid))
        else $error("skid filled without a stalled output");
`endif

endmodule
